// File: sv/kphd_pkg.sv
// ----------------------------------------------------------------------------
// kphd_pkg
// Shared types and constants of the key press and hold detector.
// ----------------------------------------------------------------------------
package kphd_pkg;

  localparam int unsigned HOLD_ENTRIES = 4;
  localparam int unsigned TIME_REGS    = 4;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 32;

  localparam logic [15:0] COUNT_MAX = 16'hffff;
  localparam logic [7:0]  NO_KEY    = 8'h00;

  localparam logic [1:0] PH_IDLE         = 2'd0;
  localparam logic [1:0] PH_PRESSED      = 2'd1;
  localparam logic [1:0] PH_WAIT_RELEASE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME_C = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME_D = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FLAG_BYTES  = 3'd5;

  typedef struct packed {
    logic [2:0]                  entry_count;
    logic [TIME_REGS-1:0][15:0]  hold_time;
    logic [TIME_REGS-1:0][7:0]   flag_bytes;
  } cfg_t;

endpackage

// File: sv/kphd_if.sv
// ----------------------------------------------------------------------------
// kphd_if
// Channel interfaces: input ticks, result items and register writes.
// ----------------------------------------------------------------------------
interface kphd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_code;
  logic       deal_done;

  modport source (output valid, key_code, deal_done, input ready);
  modport sink   (input valid, key_code, deal_done, output ready);
endinterface

interface kphd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  key_name;
  logic        press_event;
  logic        release_event;
  logic [7:0]  hold_flags;
  logic [15:0] hold_ticks;
  logic        has_key;

  modport source (output valid, key_name, press_event, release_event, hold_flags,
                  hold_ticks, has_key, input ready);
  modport sink   (input valid, key_name, press_event, release_event, hold_flags,
                  hold_ticks, has_key, output ready);
endinterface

interface kphd_cfg_if;
  import kphd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/kphd_cfg.sv
// ----------------------------------------------------------------------------
// kphd_cfg
// Configuration register file: entry count, hold times and flag bytes.
// ----------------------------------------------------------------------------
module kphd_cfg (
  input  logic            clk,
  input  logic            rst_n,
  kphd_cfg_if.sink        cfg_ch,
  output kphd_pkg::cfg_t  cfg
);
  import kphd_pkg::*;

  cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_ENTRY_COUNT: cfg_r.entry_count  <= cfg_ch.data[2:0];
        REG_HOLD_TIME_A: cfg_r.hold_time[0] <= cfg_ch.data[15:0];
        REG_HOLD_TIME_B: cfg_r.hold_time[1] <= cfg_ch.data[15:0];
        REG_HOLD_TIME_C: cfg_r.hold_time[2] <= cfg_ch.data[15:0];
        REG_HOLD_TIME_D: cfg_r.hold_time[3] <= cfg_ch.data[15:0];
        REG_FLAG_BYTES:  cfg_r.flag_bytes   <= cfg_ch.data;
        default: ;
      endcase
    end
  end

endmodule

// File: sv/kphd_match.sv
// ----------------------------------------------------------------------------
// kphd_match
// Hold table lookup: flag byte of the first active entry equal to the count.
// ----------------------------------------------------------------------------
module kphd_match (
  input  kphd_pkg::cfg_t  cfg,
  input  logic [15:0]     count,
  output logic [7:0]      flags
);
  import kphd_pkg::*;

  localparam int unsigned N_ACT = (HOLD_ENTRIES < TIME_REGS) ? HOLD_ENTRIES : TIME_REGS;

  logic [3:0] n_used;
  logic [3:0] lim;

  assign lim    = 4'(N_ACT);
  assign n_used = ({1'b0, cfg.entry_count} > lim) ? lim : {1'b0, cfg.entry_count};

  always_comb begin
    flags = '0;
    for (int i = N_ACT - 1; i >= 0; i--) begin
      if ((4'(i) < n_used) && (cfg.hold_time[i] == count)) begin
        flags = cfg.flag_bytes[i];
      end
    end
  end

endmodule

// File: sv/key_press_hold_detector_core.sv
// ----------------------------------------------------------------------------
// key_press_hold_detector_core
// Key press, hold and release detector on scanned 10 ms key ticks.
//
// in_ch takes one tick item per handshake: key code (0 = no key) and the
// application's handled flag. out_ch returns exactly one result item per
// tick: latched key, press and release events, matched hold flag byte,
// saturating hold tick count and the sticky has-key mark. cfg_ch writes the
// entry count, four hold times and the packed flag bytes; it is always ready.
// The result is registered: one input register, then the phase machine and
// table compare into the result register. Throughput is one item per cycle
// while out_ch does not stall. When out_ch stalls, the result register holds
// and the input register fills; in_ch ready drops only when both are full.
// Reset clears the phase to idle, the hold count, key, has-key mark and the
// valid flags of both pipeline stages.
// ----------------------------------------------------------------------------
module key_press_hold_detector_core (
  input  logic      clk,
  input  logic      rst_n,
  kphd_in_if.sink   in_ch,
  kphd_out_if.source out_ch,
  kphd_cfg_if.sink  cfg_ch
);
  import kphd_pkg::*;

  cfg_t        cfg;
  logic        s1_valid_r;
  logic [7:0]  s1_code_r;
  logic        s1_done_r;
  logic        out_valid_r;
  logic        s2_take;
  logic        s1_load;

  logic [1:0]  phase_r, phase_nxt;
  logic [15:0] hold_count_r, hold_count_nxt;
  logic [7:0]  current_key_r, current_key_nxt;
  logic        seen_key_r, seen_key_nxt;
  logic        press_nxt, release_nxt;
  logic [15:0] count_inc;
  logic [7:0]  match_flags;
  logic [7:0]  flags_nxt;

  logic        press_r, release_r, has_key_r;
  logic [7:0]  key_name_r, flags_r;
  logic [15:0] ticks_r;

  kphd_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  assign count_inc = (hold_count_r == COUNT_MAX) ? hold_count_r : hold_count_r + 16'd1;

  kphd_match u_match (
    .cfg   (cfg),
    .count (count_inc),
    .flags (match_flags)
  );

  assign s2_take     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s2_take;
  assign s1_load     = in_ch.valid && in_ch.ready;

  always_comb begin
    phase_nxt       = phase_r;
    hold_count_nxt  = hold_count_r;
    current_key_nxt = current_key_r;
    seen_key_nxt    = seen_key_r;
    press_nxt       = 1'b0;
    release_nxt     = 1'b0;
    flags_nxt       = '0;
    case (phase_r)
      PH_IDLE: begin
        hold_count_nxt  = '0;
        current_key_nxt = s1_code_r;
        if (s1_code_r != NO_KEY) begin
          phase_nxt = PH_PRESSED;
          press_nxt = 1'b1;
        end
      end
      PH_PRESSED: begin
        seen_key_nxt   = 1'b1;
        hold_count_nxt = count_inc;
        flags_nxt      = match_flags;
        if (s1_done_r) begin
          phase_nxt = PH_WAIT_RELEASE;
        end
      end
      PH_WAIT_RELEASE: begin
        if (s1_code_r == NO_KEY) begin
          phase_nxt   = PH_IDLE;
          release_nxt = !s1_done_r;
        end
      end
      default: begin
        current_key_nxt = NO_KEY;
        phase_nxt       = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      phase_r       <= PH_IDLE;
      hold_count_r  <= '0;
      current_key_r <= NO_KEY;
      seen_key_r    <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_r <= 1'b1;
      end else if (s2_take) begin
        s1_valid_r <= 1'b0;
      end
      if (s2_take) begin
        out_valid_r   <= 1'b1;
        phase_r       <= phase_nxt;
        hold_count_r  <= hold_count_nxt;
        current_key_r <= current_key_nxt;
        seen_key_r    <= seen_key_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_code_r <= in_ch.key_code;
      s1_done_r <= in_ch.deal_done;
    end
    if (s2_take) begin
      key_name_r <= current_key_nxt;
      press_r    <= press_nxt;
      release_r  <= release_nxt;
      flags_r    <= flags_nxt;
      ticks_r    <= hold_count_nxt;
      has_key_r  <= seen_key_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.key_name      = key_name_r;
  assign out_ch.press_event   = press_r;
  assign out_ch.release_event = release_r;
  assign out_ch.hold_flags    = flags_r;
  assign out_ch.hold_ticks    = ticks_r;
  assign out_ch.has_key       = has_key_r;

endmodule
